@@ rtl/tspbb_pkg.sv @@
package tspbb_pkg;

  // Fixed field widths of the two stream channels.
  localparam int unsigned IN_W   = 16;
  localparam int unsigned CITY_W = 3;
  localparam int unsigned COST_W = 20;
  localparam int unsigned OUT_W  = CITY_W + COST_W + 1;

  typedef logic [IN_W-1:0]  in_data_t;
  typedef logic [OUT_W-1:0] out_data_t;

endpackage

@@ rtl/tspbb_ram.sv @@
module tspbb_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/tsp_branch_and_bound_search_unit.sv @@
// Channel | Direction | Transaction contents
// in_     | slave     | one weight of the matrix, row-major order
// out_    | master    | one city of the best tour with its cost and found flag
//
// Loading writes each accepted weight to the store. After the last weight, a
// row-minimum pass reads every entry, then the search runs for a data-dependent
// time: each edge tried is read, each usable edge gets a bound compared with the
// best cost, each closing edge is read, and a used-up level returns to its parent.
// All weights go through one RAM read port.
// in_tready is low from the last weight until the last result is taken; the
// results then leave one per cycle while out_tready is high.
// Reset is synchronous and clears the sequencer; the matrix store is not cleared.
module tsp_branch_and_bound_search_unit #(
  parameter int unsigned CITIES      = 4,
  parameter int unsigned WEIGHT_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  tspbb_pkg::in_data_t        in_tdata,   // [15:0] weight
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output tspbb_pkg::out_data_t       out_tdata,  // [2:0] city, [22:3] tour_cost, [23] found
  output logic                       out_tlast   // final_item
);
  import tspbb_pkg::*;

  localparam int unsigned CELLS = CITIES * CITIES;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned CIW   = $clog2(CITIES);
  localparam int unsigned NW    = $clog2(CITIES + 1);
  localparam int unsigned WB    = WEIGHT_BITS;
  localparam int unsigned SW    = WB + 5;
  localparam int unsigned CW    = WB + 6;

  localparam logic [3:0] S_LOAD = 4'd0;
  localparam logic [3:0] S_MRD  = 4'd1;
  localparam logic [3:0] S_MDAT = 4'd2;
  localparam logic [3:0] S_INIT = 4'd3;
  localparam logic [3:0] S_EDGE = 4'd4;
  localparam logic [3:0] S_EDAT = 4'd5;
  localparam logic [3:0] S_MSEL = 4'd6;
  localparam logic [3:0] S_BND  = 4'd7;
  localparam logic [3:0] S_CMP  = 4'd8;
  localparam logic [3:0] S_LEAF = 4'd9;
  localparam logic [3:0] S_LDAT = 4'd10;
  localparam logic [3:0] S_OUT  = 4'd11;

  localparam logic [WB:0] NONE_MIN = '1;

  logic [3:0]            state_r;
  logic [AW-1:0]         load_cnt_r;
  logic [CIW-1:0]        mrow_r, mcol_r;
  logic [AW-1:0]         mbase_r;
  logic [WB:0]           amin_r, bmin_r;
  logic [SW-1:0]         sum_r;
  logic [WB-1:0]         fmin_r [CITIES];
  logic [WB-1:0]         smin_r [CITIES];
  logic [CIW-1:0]        lvl_r;
  logic [CITIES-1:0]     visited_r;
  logic [CIW-1:0]        path_r [CITIES];
  logic signed [CW-1:0]  bound_r [CITIES];
  logic signed [CW-1:0]  wsum_r [CITIES];
  logic [NW-1:0]         next_r [CITIES];
  logic [WB-1:0]         edge_r;
  logic [WB-1:0]         m_r;
  logic signed [CW-1:0]  nb_r, nw_r;
  logic                  best_valid_r;
  logic signed [CW-1:0]  best_r;
  logic [CIW-1:0]        best_path_r [CITIES+1];
  logic [NW-1:0]         ocnt_r;

  logic                  ram_we;
  logic [AW-1:0]         ram_raddr;
  logic [WB-1:0]         ram_rdata;
  logic [WB-1:0]         w_in;
  logic [WB+IN_W-1:0]    w_ext;
  logic [WB:0]           v_ext, amin_nxt, bmin_nxt;
  logic [NW-1:0]         cur_i;
  logic [CIW-1:0]        cur_ic, prev_c;
  logic [CIW-1:0]        mm_idx;
  logic [WB-1:0]         mm_val;
  logic signed [CW-1:0]  edge_s, rd_s, leaf_tot;
  logic [CW+COST_W-1:0]  cost_ext;
  logic [CIW+CITY_W-1:0] city_ext;

  // Incoming weights are cut or widened to the stored weight width.
  assign w_ext = {{WB{1'b0}}, in_tdata};
  assign w_in  = w_ext[WB-1:0];
  assign ram_we = in_tvalid && in_tready;

  tspbb_ram #(
    .WIDTH (WB),
    .DEPTH (CELLS)
  ) u_weights (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (load_cnt_r),
    .wr_data (w_in),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // Current search indices.
  assign cur_i  = next_r[lvl_r];
  assign cur_ic = cur_i[CIW-1:0];
  assign prev_c = path_r[lvl_r - CIW'(1)];

  // Single read address into the weight store, chosen by the sequencer.
  always_comb begin
    unique case (state_r)
      S_MRD:   ram_raddr = mbase_r + AW'(mcol_r);
      S_LEAF:  ram_raddr = AW'(32'(cur_ic) * CITIES);
      default: ram_raddr = AW'(32'(prev_c) * CITIES + 32'(cur_ic));
    endcase
  end

  // First and second minimum update for one off-diagonal entry.
  always_comb begin
    v_ext    = {1'b0, ram_rdata};
    amin_nxt = amin_r;
    bmin_nxt = bmin_r;
    if (mcol_r != mrow_r) begin
      if (v_ext <= amin_r) begin
        bmin_nxt = amin_r;
        amin_nxt = v_ext;
      end else if (v_ext <= bmin_r && v_ext != amin_r) begin
        bmin_nxt = v_ext;
      end
    end
  end

  // One read of the row-minimum tables per cycle.
  assign mm_idx = (state_r == S_MSEL) ? prev_c : cur_ic;
  assign mm_val = (state_r == S_MSEL && lvl_r != CIW'(1)) ? smin_r[mm_idx] : fmin_r[mm_idx];

  assign edge_s   = CW'(signed'({1'b0, edge_r}));
  assign rd_s     = CW'(signed'({1'b0, ram_rdata}));
  assign leaf_tot = nw_r + rd_s;

  // Main sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_LOAD;
      load_cnt_r   <= '0;
      lvl_r        <= '0;
      visited_r    <= '0;
      best_valid_r <= 1'b0;
      ocnt_r       <= '0;
    end else begin
      unique case (state_r)
        S_LOAD: begin
          if (ram_we) begin
            if (load_cnt_r == AW'(CELLS - 1)) begin
              load_cnt_r <= '0;
              mrow_r     <= '0;
              mcol_r     <= '0;
              mbase_r    <= '0;
              amin_r     <= NONE_MIN;
              bmin_r     <= NONE_MIN;
              sum_r      <= '0;
              state_r    <= S_MRD;
            end else begin
              load_cnt_r <= load_cnt_r + AW'(1);
            end
          end
        end
        S_MRD: begin
          state_r <= S_MDAT;
        end
        S_MDAT: begin
          if (mcol_r == CIW'(CITIES - 1)) begin
            fmin_r[mrow_r] <= amin_nxt[WB-1:0];
            smin_r[mrow_r] <= bmin_nxt[WB-1:0];
            sum_r   <= sum_r + SW'(amin_nxt) + SW'(bmin_nxt);
            amin_r  <= NONE_MIN;
            bmin_r  <= NONE_MIN;
            mcol_r  <= '0;
            mrow_r  <= mrow_r + CIW'(1);
            mbase_r <= mbase_r + AW'(CITIES);
            state_r <= (mrow_r == CIW'(CITIES - 1)) ? S_INIT : S_MRD;
          end else begin
            amin_r  <= amin_nxt;
            bmin_r  <= bmin_nxt;
            mcol_r  <= mcol_r + CIW'(1);
            state_r <= S_MRD;
          end
        end
        S_INIT: begin
          bound_r[1]   <= CW'(signed'({1'b0, (sum_r + SW'(1)) >> 1}));
          wsum_r[1]    <= '0;
          next_r[1]    <= '0;
          path_r[0]    <= '0;
          lvl_r        <= CIW'(1);
          visited_r    <= CITIES'(1);
          best_valid_r <= 1'b0;
          state_r      <= S_EDGE;
        end
        S_EDGE: begin
          if (cur_i == NW'(CITIES)) begin
            if (lvl_r == CIW'(1)) begin
              ocnt_r  <= '0;
              state_r <= S_OUT;
            end else begin
              // Return to the parent level and try its next city.
              visited_r[path_r[lvl_r - CIW'(1)]] <= 1'b0;
              next_r[lvl_r - CIW'(1)] <= next_r[lvl_r - CIW'(1)] + NW'(1);
              lvl_r <= lvl_r - CIW'(1);
            end
          end else begin
            state_r <= S_EDAT;
          end
        end
        S_EDAT: begin
          if (ram_rdata == '0 || visited_r[cur_ic]) begin
            next_r[lvl_r] <= cur_i + NW'(1);
            state_r       <= S_EDGE;
          end else begin
            edge_r  <= ram_rdata;
            state_r <= S_MSEL;
          end
        end
        S_MSEL: begin
          m_r     <= mm_val;
          state_r <= S_BND;
        end
        S_BND: begin
          nb_r    <= bound_r[lvl_r] - CW'(({1'b0, m_r} + {1'b0, mm_val}) >> 1);
          nw_r    <= wsum_r[lvl_r] + edge_s;
          state_r <= S_CMP;
        end
        S_CMP: begin
          if (!best_valid_r || (nb_r + nw_r) < best_r) begin
            if (lvl_r == CIW'(CITIES - 1)) begin
              state_r <= S_LEAF;
            end else begin
              // Descend one level with the new city on the path.
              path_r[lvl_r]            <= cur_ic;
              visited_r[cur_ic]        <= 1'b1;
              bound_r[lvl_r + CIW'(1)] <= nb_r;
              wsum_r[lvl_r + CIW'(1)]  <= nw_r;
              next_r[lvl_r + CIW'(1)]  <= '0;
              lvl_r                    <= lvl_r + CIW'(1);
              state_r                  <= S_EDGE;
            end
          end else begin
            next_r[lvl_r] <= cur_i + NW'(1);
            state_r       <= S_EDGE;
          end
        end
        S_LEAF: begin
          state_r <= S_LDAT;
        end
        S_LDAT: begin
          // Close the tour back to city 0 and keep it on a strict improvement.
          if (ram_rdata != '0 && (!best_valid_r || leaf_tot < best_r)) begin
            best_r       <= leaf_tot;
            best_valid_r <= 1'b1;
            for (int k = 0; k < CITIES - 1; k++) begin
              best_path_r[k] <= path_r[k];
            end
            best_path_r[CITIES-1] <= cur_ic;
            best_path_r[CITIES]   <= '0;
          end
          next_r[lvl_r] <= cur_i + NW'(1);
          state_r       <= S_EDGE;
        end
        S_OUT: begin
          if (out_tready) begin
            if (out_tlast) begin
              state_r <= S_LOAD;
            end else begin
              ocnt_r <= ocnt_r + NW'(1);
            end
          end
        end
        default: begin
          state_r <= S_LOAD;
        end
      endcase
    end
  end

  // Result fields.
  assign cost_ext   = {{COST_W{1'b0}}, best_r};
  assign city_ext   = {{CITY_W{1'b0}}, best_path_r[ocnt_r]};
  assign in_tready  = (state_r == S_LOAD);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tlast  = !best_valid_r || (ocnt_r == NW'(CITIES));

  always_comb begin
    if (best_valid_r) begin
      out_tdata = {1'b1, cost_ext[COST_W-1:0], city_ext[CITY_W-1:0]};
    end else begin
      out_tdata = '0;
    end
  end

endmodule
